// ===== rtl/dfs_topological_sort_assert.svh =====
// Assertion macros used by the checker file of the topological sort block.
// No dependencies; include by bare file name.
`ifndef DFS_TOPOLOGICAL_SORT_ASSERT_SVH
`define DFS_TOPOLOGICAL_SORT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dts_pkg.sv =====
// Package for the depth-first topological sort block: item types, command
// codes, sequencer states and parameter defaults. No dependencies.
package dts_pkg;

    localparam int NUM_VERTICES_DEF = 16;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_SORT  = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] from_vertex;
        logic [3:0] to_vertex;
    } t_cmd;

    typedef struct packed {
        logic [3:0] vertex;
        logic       last;
        logic       edges_dropped;
    } t_result;

    // Control from the walk sequencer to the output stage.
    typedef struct packed {
        logic go;
        logic drop;
        logic fin_we;
    } t_walk_emit;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ADD   = 7'b0000010,
        S_DEG   = 7'b0000100,
        S_STEP  = 7'b0001000,
        S_EDGE  = 7'b0010000,
        S_POP   = 7'b0100000,
        S_SWEEP = 7'b1000000
    } t_walk_state;

endpackage

// ===== rtl/dts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/dts_walk.sv =====
// Command sequencer: graph loading and the stack-based depth-first walk.
// Depends on dts_pkg and dts_ram (edge store, degree counts, walk stack).
module dts_walk
    import dts_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  t_cmd                            i_cmd,
    output logic                            o_busy,
    output t_walk_emit                      o_emit,
    output logic [$clog2(NUM_VERTICES)-1:0] o_fin_addr,
    output logic [$clog2(NUM_VERTICES)-1:0] o_fin_data
);

    localparam int VW     = $clog2(NUM_VERTICES);
    localparam int VCW    = $clog2(NUM_VERTICES + 1);
    localparam int DW     = $clog2(MAX_DEGREE + 1);
    localparam int EDEPTH = NUM_VERTICES * MAX_DEGREE;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int FW     = VW + DW;

    t_walk_state            r_state, n_state;
    logic [NUM_VERTICES-1:0] r_deg_vld, n_deg_vld;
    logic [NUM_VERTICES-1:0] r_visited, n_visited;
    logic                   r_drop, n_drop;
    logic [VW-1:0]          r_sp, n_sp;
    logic [VW-1:0]          r_fcount, n_fcount;
    logic [VCW-1:0]         r_j, n_j;
    logic [VW-1:0]          r_cur_v, n_cur_v;
    logic [DW-1:0]          r_cur_idx, n_cur_idx;
    logic [DW-1:0]          r_cur_deg, n_cur_deg;
    logic [VW-1:0]          r_add_v, n_add_v;
    logic [3:0]             r_add_w, n_add_w;
    logic                   r_deg_rd_vld;

    logic                   from_ok, to_ok;
    logic [DW-1:0]          deg_rdata, deg_eff;
    logic [VW-1:0]          deg_raddr;
    logic                   deg_we;
    logic [3:0]             edge_rdata;
    logic                   edge_we;
    logic [EAW-1:0]         edge_waddr, edge_raddr;
    logic [FW-1:0]          walk_rdata;
    logic                   walk_we;
    logic                   begin_v;
    logic [VW-1:0]          begin_vtx;
    logic [VW-1:0]          edge_w;
    logic                   emit_go, fin_we;

    assign from_ok = (7'(i_cmd.from_vertex) < 7'(NUM_VERTICES));
    assign to_ok   = (7'(i_cmd.to_vertex) < 7'(NUM_VERTICES));
    // A degree entry not written since the last clear reads as zero.
    assign deg_eff = r_deg_rd_vld ? deg_rdata : '0;
    assign edge_w  = VW'(edge_rdata);

    assign edge_raddr = EAW'(r_cur_v) * EAW'(MAX_DEGREE) + EAW'(r_cur_idx);
    assign edge_waddr = EAW'(r_add_v) * EAW'(MAX_DEGREE) + EAW'(deg_eff);

    dts_ram #(.WIDTH(DW), .DEPTH(NUM_VERTICES)) u_deg_ram (
        .i_clk   (i_clk),
        .i_we    (deg_we),
        .i_waddr (r_add_v),
        .i_wdata (deg_eff + DW'(1)),
        .i_raddr (deg_raddr),
        .o_rdata (deg_rdata)
    );

    dts_ram #(.WIDTH(4), .DEPTH(EDEPTH)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (r_add_w),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    dts_ram #(.WIDTH(FW), .DEPTH(NUM_VERTICES)) u_walk_ram (
        .i_clk   (i_clk),
        .i_we    (walk_we),
        .i_waddr (r_sp),
        .i_wdata ({r_cur_v, r_cur_idx}),
        .i_raddr (r_sp - 1'b1),
        .o_rdata (walk_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_deg_vld = r_deg_vld;
        n_visited = r_visited;
        n_drop    = r_drop;
        n_sp      = r_sp;
        n_fcount  = r_fcount;
        n_j       = r_j;
        n_cur_v   = r_cur_v;
        n_cur_idx = r_cur_idx;
        n_cur_deg = r_cur_deg;
        n_add_v   = r_add_v;
        n_add_w   = r_add_w;
        deg_raddr = r_cur_v;
        deg_we    = 1'b0;
        edge_we   = 1'b0;
        walk_we   = 1'b0;
        begin_v   = 1'b0;
        begin_vtx = r_cur_v;
        emit_go   = 1'b0;
        fin_we    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_cmd.mode)
                        MODE_CLEAR: begin
                            n_deg_vld = '0;
                            n_drop    = 1'b0;
                        end
                        MODE_ADD: begin
                            if (from_ok && to_ok) begin
                                n_add_v   = VW'(i_cmd.from_vertex);
                                n_add_w   = i_cmd.to_vertex;
                                deg_raddr = VW'(i_cmd.from_vertex);
                                n_state   = S_ADD;
                            end else begin
                                n_drop = 1'b1;
                            end
                        end
                        MODE_SORT: begin
                            n_visited = '0;
                            n_fcount  = '0;
                            n_j       = '0;
                            n_sp      = '0;
                            if (from_ok) begin
                                begin_v   = 1'b1;
                                begin_vtx = VW'(i_cmd.from_vertex);
                            end else begin
                                n_state = S_SWEEP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD: begin
                if (deg_eff >= DW'(MAX_DEGREE)) begin
                    n_drop = 1'b1;
                end else begin
                    edge_we            = 1'b1;
                    deg_we             = 1'b1;
                    n_deg_vld[r_add_v] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_DEG: begin
                n_cur_deg = deg_eff;
                n_state   = S_STEP;
            end
            S_STEP: begin
                // The shared compare: is there another edge left on the top vertex?
                if (r_cur_idx < r_cur_deg) begin
                    n_cur_idx = r_cur_idx + 1'b1;
                    n_state   = S_EDGE;
                end else begin
                    fin_we   = 1'b1;
                    n_fcount = r_fcount + 1'b1;
                    if (r_sp == '0) begin
                        n_state = S_SWEEP;
                    end else begin
                        n_sp    = r_sp - 1'b1;
                        n_state = S_POP;
                    end
                end
            end
            S_EDGE: begin
                if (!r_visited[edge_w]) begin
                    walk_we   = 1'b1;
                    n_sp      = r_sp + 1'b1;
                    begin_v   = 1'b1;
                    begin_vtx = edge_w;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_POP: begin
                n_cur_v   = walk_rdata[FW-1:DW];
                n_cur_idx = walk_rdata[DW-1:0];
                deg_raddr = walk_rdata[FW-1:DW];
                n_state   = S_DEG;
            end
            S_SWEEP: begin
                if (r_j == VCW'(NUM_VERTICES)) begin
                    emit_go = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                    if (!r_visited[r_j[VW-1:0]]) begin
                        begin_v   = 1'b1;
                        begin_vtx = r_j[VW-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Opening a vertex: mark it, make it the top frame, fetch its degree.
        if (begin_v) begin
            n_visited[begin_vtx] = 1'b1;
            n_cur_v              = begin_vtx;
            n_cur_idx            = '0;
            deg_raddr            = begin_vtx;
            n_state              = S_DEG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_deg_vld <= '0;
            r_visited <= '0;
            r_drop    <= 1'b0;
            r_sp      <= '0;
            r_fcount  <= '0;
            r_j       <= '0;
        end else begin
            r_state   <= n_state;
            r_deg_vld <= n_deg_vld;
            r_visited <= n_visited;
            r_drop    <= n_drop;
            r_sp      <= n_sp;
            r_fcount  <= n_fcount;
            r_j       <= n_j;
        end
        r_cur_v      <= n_cur_v;
        r_cur_idx    <= n_cur_idx;
        r_cur_deg    <= n_cur_deg;
        r_add_v      <= n_add_v;
        r_add_w      <= n_add_w;
        r_deg_rd_vld <= r_deg_vld[deg_raddr];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_emit.go   = emit_go;
    assign o_emit.drop = r_drop;
    assign o_emit.fin_we = fin_we;
    assign o_fin_addr  = r_fcount;
    assign o_fin_data  = r_cur_v;

endmodule

// ===== rtl/dts_emit.sv =====
// Output stage: holds the finish order and plays it back newest first.
// Depends on dts_pkg and dts_ram (finish stack).
module dts_emit
    import dts_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_walk_emit                      i_ctl,
    input  logic [$clog2(NUM_VERTICES)-1:0] i_fin_addr,
    input  logic [$clog2(NUM_VERTICES)-1:0] i_fin_data,
    output logic                            o_busy,
    output logic                            o_strobe,
    output t_result                         o_result
);

    localparam int VW = $clog2(NUM_VERTICES);

    logic          r_act;
    logic [VW-1:0] r_addr;
    logic          r_pend;
    logic          r_pend_last;
    logic          r_drop;
    logic [VW-1:0] fin_rdata;

    dts_ram #(.WIDTH(VW), .DEPTH(NUM_VERTICES)) u_fin_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.fin_we),
        .i_waddr (i_fin_addr),
        .i_wdata (i_fin_data),
        .i_raddr (r_addr),
        .o_rdata (fin_rdata)
    );

    // Every vertex finishes exactly once, so the stack is always full here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_pend <= r_act;
            if (i_ctl.go) begin
                r_act <= 1'b1;
            end else if (r_act && r_addr == '0) begin
                r_act <= 1'b0;
            end
        end
        if (i_ctl.go) begin
            r_addr <= VW'(NUM_VERTICES - 1);
            r_drop <= i_ctl.drop;
        end else if (r_act) begin
            r_addr <= r_addr - 1'b1;
        end
        r_pend_last <= r_act && (r_addr == '0);
    end

    assign o_busy                 = r_act | r_pend;
    assign o_strobe               = r_pend;
    assign o_result.vertex        = 4'(fin_rdata);
    assign o_result.last          = r_pend_last;
    assign o_result.edges_dropped = r_pend_last & r_drop;

endmodule

// ===== rtl/dfs_topological_sort.sv =====
// Depth-first topological sort over a stored directed graph.
//
// Commands come in on i_cmd and are taken when start is high and busy is low.
// A clear resets all edge counts and the dropped-edge flag. An add appends the
// edge to the tail vertex's list; an edge naming a vertex out of range, or
// landing on a full list, is dropped and sets the flag. A sort walks the graph
// from the given source if it is in range, then from every unvisited vertex in
// ascending order, with a stack kept in RAM, and then plays back all NUM_VERTICES
// vertices in reverse finish order: one item per cycle on o_result, marked by
// o_strobe, the final one with last set and carrying the dropped-edge flag.
// busy stays high until the last item has been shown.
// While a sort holds busy, each edge costs a compare and an edge fetch, each
// vertex a degree read and a finish step, and each non-root vertex also a stack
// pop and a degree re-read of its parent; a sweep over all vertex numbers and
// the output playback follow, all paced by the registered RAM reads.
// Reset empties the graph and clears the flag. The receiver cannot stall;
// results are never held back.
// Depends on dts_pkg, dts_walk and dts_emit.
module dfs_topological_sort
    import dts_pkg::*;
#(
    parameter int NUM_VERTICES = NUM_VERTICES_DEF,
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int VW = $clog2(NUM_VERTICES);

    logic          walk_busy;
    logic          emit_busy;
    logic          accept;
    t_walk_emit    walk_emit;
    logic [VW-1:0] fin_addr;
    logic [VW-1:0] fin_data;

    assign accept = start & ~busy;
    assign busy   = walk_busy | emit_busy;

    dts_walk #(
        .NUM_VERTICES (NUM_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_walk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_cmd      (i_cmd),
        .o_busy     (walk_busy),
        .o_emit     (walk_emit),
        .o_fin_addr (fin_addr),
        .o_fin_data (fin_data)
    );

    dts_emit #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (walk_emit),
        .i_fin_addr (fin_addr),
        .i_fin_data (fin_data),
        .o_busy     (emit_busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/dts_checker.sv =====
// Port-level checks for the topological sort block, bound to its top level.
// Depends on dts_pkg and dfs_topological_sort_assert.svh.
`include "dfs_topological_sort_assert.svh"

module dts_checker
    import dts_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_cmd    i_cmd,
    input logic    o_strobe,
    input t_result o_result
);

    // Results only appear while a sort is in progress.
    `DTS_ASSERT_SAME(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy, "result item outside a sort")
    // The final item of a sort is not directly followed by another one.
    `DTS_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_strobe && o_result.last, !o_strobe, "result item after last")
    // The dropped-edge flag is only reported on the final item.
    `DTS_ASSERT_SAME(a_drop_last, i_clk, i_rst_n, o_strobe && !o_result.last, !o_result.edges_dropped, "drop flag on non-final item")
    // An accepted sort keeps the block busy.
    `DTS_ASSERT_NEXT(a_sort_busy, i_clk, i_rst_n, start && !busy && i_cmd.mode == MODE_SORT, busy, "sort did not raise busy")

endmodule

bind dfs_topological_sort dts_checker u_chk (.*);

// ===== tb/sv/dfs_topological_sort_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for dfs_topological_sort: graph loads, sorts and ignored commands.
// Keeps its own copy of the graph and predicts each sort order. Depends on dts_pkg and the RTL.
module dfs_topological_sort_test;
    import dts_pkg::*;

    localparam int NV           = NUM_VERTICES_DEF;
    localparam int MAX_DEG      = MAX_DEGREE_DEF;
    localparam int TARGET_ITEMS = 420;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    // Shadow copy of the graph held by the block.
    logic [3:0] adj_to [NV][MAX_DEG];
    int         out_deg [NV];
    logic       drop_seen;
    logic       seen_mark [NV];
    int         finish_seq [$];

    t_result    order_q [$];
    t_result    exp_r;
    bit         fast_run;
    int         n_sent;
    int         n_sorts;
    int         n_results;
    int         n_errors;

    always #5 i_clk = ~i_clk;

    dfs_topological_sort u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    function automatic t_cmd mk_cmd(input logic [1:0] m, input logic [3:0] f,
                                    input logic [3:0] t);
        t_cmd c;
        c.mode        = m;
        c.from_vertex = f;
        c.to_vertex   = t;
        return c;
    endfunction

    // Depth-first walk from one root with an explicit stack; appends finished vertices.
    function automatic void walk_tree(input int root);
        int st_v [NV];
        int st_i [NV];
        int sp;
        int v;
        int idx;
        int w;
        seen_mark[root] = 1'b1;
        st_v[0] = root;
        st_i[0] = 0;
        sp = 1;
        while (sp > 0) begin
            v = st_v[sp-1];
            idx = st_i[sp-1];
            if (idx < out_deg[v] && idx < MAX_DEG) begin
                w = int'(adj_to[v][idx]);
                st_i[sp-1] = idx + 1;
                if (!seen_mark[w] && sp < NV) begin
                    seen_mark[w] = 1'b1;
                    st_v[sp] = w;
                    st_i[sp] = 0;
                    sp++;
                end
            end else begin
                sp--;
                if (finish_seq.size() < NV) finish_seq.push_back(v);
            end
        end
    endfunction

    function automatic void predict_order(input logic [3:0] src);
        t_result r;
        int      cnt;
        for (int j = 0; j < NV; j++) seen_mark[j] = 1'b0;
        finish_seq.delete();
        walk_tree(int'(src));
        for (int j = 0; j < NV; j++) begin
            if (!seen_mark[j]) walk_tree(j);
        end
        cnt = finish_seq.size();
        for (int k = 0; k < cnt; k++) begin
            r.vertex        = 4'(finish_seq[cnt-1-k]);
            r.last          = (k == cnt - 1);
            r.edges_dropped = (k == cnt - 1) ? drop_seen : 1'b0;
            order_q.push_back(r);
        end
    endfunction

    function automatic void apply_cmd(input t_cmd c);
        case (c.mode)
            MODE_CLEAR: begin
                for (int j = 0; j < NV; j++) out_deg[j] = 0;
                drop_seen = 1'b0;
            end
            MODE_ADD: begin
                if (out_deg[c.from_vertex] >= MAX_DEG) begin
                    drop_seen = 1'b1;
                end else begin
                    adj_to[c.from_vertex][out_deg[c.from_vertex]] = c.to_vertex;
                    out_deg[c.from_vertex]++;
                end
            end
            MODE_SORT: begin
                n_sorts++;
                predict_order(c.from_vertex);
            end
            default: ;
        endcase
    endfunction

    // Start is left high after acceptance so that a back-to-back item keeps it high;
    // within this task it is lowered only when a gap follows.
    task automatic send_cmd(input t_cmd c);
        int gap;
        bit ok;
        gap = fast_run ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        apply_cmd(c);
        if (c.mode != MODE_UNUSED) n_sent++;
    endtask

    task automatic drain_wait();
        start <= 1'b0;
        @(posedge i_clk);
        while (order_q.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            n_results++;
            if (order_q.size() == 0) begin
                $error("unexpected result: vertex %0d last %0b edges_dropped %0b",
                       o_result.vertex, o_result.last, o_result.edges_dropped);
                n_errors++;
            end else begin
                exp_r = order_q.pop_front();
                if (o_result.vertex !== exp_r.vertex) begin
                    $error("vertex: expected %0d, got %0d", exp_r.vertex, o_result.vertex);
                    n_errors++;
                end
                if (o_result.last !== exp_r.last) begin
                    $error("last: expected %0b, got %0b", exp_r.last, o_result.last);
                    n_errors++;
                end
                if (o_result.edges_dropped !== exp_r.edges_dropped) begin
                    $error("edges_dropped: expected %0b, got %0b",
                           exp_r.edges_dropped, o_result.edges_dropped);
                    n_errors++;
                end
            end
        end
    end

    task automatic test_empty_sort();
        send_cmd(mk_cmd(MODE_SORT, 4'd0, 4'd15));
    endtask

    task automatic test_self_loop_and_ends();
        send_cmd(mk_cmd(MODE_CLEAR, 4'd15, 4'd15));
        send_cmd(mk_cmd(MODE_ADD, 4'd0, 4'd0));
        send_cmd(mk_cmd(MODE_ADD, 4'd15, 4'd0));
        send_cmd(mk_cmd(MODE_ADD, 4'd0, 4'd15));
        send_cmd(mk_cmd(MODE_SORT, 4'd15, 4'd0));
    endtask

    // One list is filled past capacity so the last add is dropped.
    task automatic test_full_list();
        send_cmd(mk_cmd(MODE_CLEAR, 4'd0, 4'd0));
        for (int k = 0; k <= MAX_DEG; k++) send_cmd(mk_cmd(MODE_ADD, 4'd15, 4'(k)));
        send_cmd(mk_cmd(MODE_UNUSED, 4'd15, 4'd15));
        drain_wait();
        send_cmd(mk_cmd(MODE_SORT, 4'd0, 4'd0));
    endtask

    task automatic test_clear_resets_flag();
        send_cmd(mk_cmd(MODE_CLEAR, 4'd0, 4'd0));
        send_cmd(mk_cmd(MODE_SORT, 4'd15, 4'd15));
    endtask

    task automatic test_random_graphs();
        int         n_edges;
        bit         dag;
        bit         dense;
        logic [3:0] a;
        logic [3:0] b;
        logic [3:0] tmp;
        while (n_sent < TARGET_ITEMS) begin
            fast_run = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_cmd(mk_cmd(MODE_CLEAR, 4'($urandom), 4'($urandom)));
            end
            dense = ($urandom_range(0, 9) == 0);
            dag = ($urandom_range(0, 1) == 1);
            n_edges = dense ? $urandom_range(40, 90) : $urandom_range(0, 24);
            for (int k = 0; k < n_edges && n_sent < TARGET_ITEMS; k++) begin
                // Dense rounds pile edges onto a few tails so that lists overflow.
                a = 4'($urandom_range(0, dense ? 3 : 15));
                b = 4'($urandom_range(0, 15));
                if (dag && a > b) begin
                    tmp = a;
                    a = b;
                    b = tmp;
                end
                if ($urandom_range(0, 24) == 0) begin
                    send_cmd(mk_cmd(MODE_UNUSED, 4'($urandom), 4'($urandom)));
                end
                send_cmd(mk_cmd(MODE_ADD, a, b));
            end
            if ($urandom_range(0, 5) == 0) drain_wait();
            repeat ($urandom_range(1, 2)) begin
                send_cmd(mk_cmd(MODE_SORT, 4'($urandom), 4'($urandom)));
            end
        end
    endtask

    initial begin
        drop_seen = 1'b0;
        for (int j = 0; j < NV; j++) out_deg[j] = 0;
        fast_run = 1'b0;
        n_sent = 0;
        n_sorts = 0;
        n_results = 0;
        n_errors = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_sort();
        test_self_loop_and_ends();
        test_full_list();
        test_clear_resets_flag();
        test_random_graphs();

        start <= 1'b0;
        for (int i = 0; i < 5000 && order_q.size() != 0; i++) @(posedge i_clk);
        if (order_q.size() != 0) begin
            $error("%0d expected results never arrived", order_q.size());
            n_errors++;
        end
        repeat (30) @(posedge i_clk);

        $display("Sent %0d commands including %0d sorts; checked %0d output vertices.",
                 n_sent, n_sorts, n_results);
        $display("Found %0d mismatches.", n_errors);
        if (n_errors == 0) begin
            $display("dfs_topological_sort_test passed");
        end else begin
            $display("dfs_topological_sort_test failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("dfs_topological_sort_test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dts_pkg.sv
rtl/dts_ram.sv
rtl/dts_walk.sv
rtl/dts_emit.sv
rtl/dfs_topological_sort.sv
rtl/dts_checker.sv
tb/sv/dfs_topological_sort_test.sv
